// ===== hdl/fpba_pkg.sv =====
// Package for the fit-policy block allocator: request, status and policy codes,
// and the command/status structs exchanged between controller and datapath.
// No dependencies.
`default_nettype none
package fpba_pkg;

  // Width of offsets and lengths; the port fields are fixed at this width.
  localparam int OFFSET_BITS = 16;

  localparam logic       REQ_ALLOC = 1'b0;
  localparam logic       REQ_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;
  // The unused policy code behaves as first fit.
  localparam logic [1:0] POL_SPARE = 2'd3;

  localparam logic       CFG_TOTAL_SIZE = 1'b0;
  localparam logic       CFG_FIT_POLICY = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init;      // reload tables from total_size
    logic load;      // capture the request
    logic scan_clr;  // clear scan results and index
    logic scan_step; // examine one entry of each table
    logic commit;    // apply the update and form the result
  } fpba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last; // current scan index is the final entry
  } fpba_sts_t;

endpackage
`default_nettype wire

// ===== hdl/fpba_ctrl.sv =====
// Controller of the fit-policy block allocator: sequences load, the table scan,
// the commit step and the output handshake. Depends on fpba_pkg.
`default_nettype none
module fpba_ctrl
  import fpba_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cfg_write,
  input  wire logic      in_fire,
  input  wire logic      out_free,
  input  fpba_sts_t      sts,
  output fpba_cmd_t      cmd,
  output logic           in_ready,
  output logic           cfg_ready
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_COMMIT = 4'b0100,
    S_INIT   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Output register sits in the datapath; a new item may enter while it holds a
  // result, and that item's commit waits until the result slot is free again.
  assign in_ready  = (state_r == S_IDLE) && !cfg_write;
  assign cfg_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (cfg_write) begin
          state_nxt = S_INIT;
        end else if (in_fire) begin
          cmd.load     = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else        state_r <= state_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/fpba_dp.sv =====
// Datapath of the fit-policy block allocator: free and used tables, the
// one-entry-per-cycle scan, the commit update and the result register.
// Depends on fpba_pkg.
`default_nettype none
module fpba_dp
  import fpba_pkg::*;
#(
  parameter int MAX_BLOCKS  = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  fpba_cmd_t                   cmd,
  output fpba_sts_t                   sts,
  input  wire logic [15:0]            total_size,
  input  wire logic [1:0]             fit_policy,
  input  wire logic                   req_type,
  input  wire logic [15:0]            req_size,
  input  wire logic [15:0]            block_offset,
  output logic                        res_valid,
  input  wire logic                   res_take,
  output logic [1:0]                  res_status,
  output logic [15:0]                 res_offset,
  output logic [15:0]                 res_free
);

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int OB = OFFSET_BITS;
  localparam logic [IW-1:0] LAST = IW'(MAX_BLOCKS - 1);

  logic [OB-1:0] fstart_r [MAX_BLOCKS];
  logic [OB-1:0] flen_r   [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] fval_r;
  logic [OB-1:0] ustart_r [MAX_BLOCKS];
  logic [OB-1:0] ulen_r   [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] uval_r;

  logic          rtype_r;
  logic [OB-1:0] rsize_r, roff_r;
  logic [IW-1:0] idx_r;

  // Scan results.
  logic          bfound_r; logic [IW-1:0] bidx_r;
  logic [OB-1:0] bstart_r, blen_r;
  logic          uemp_found_r; logic [IW-1:0] uemp_r;
  logic          femp_found_r; logic [IW-1:0] femp_r;
  logic          hit_r;  logic [IW-1:0] hit_idx_r;
  logic [OB-1:0] hit_len_r;
  logic          above_r; logic [IW-1:0] above_idx_r;
  logic          below_r; logic [IW-1:0] below_idx_r;
  logic [OB:0]   sum_r;

  logic          res_valid_r;
  logic [1:0]    st_r;
  logic [15:0]   ofs_r, fr_r;

  assign sts.scan_last = (idx_r == LAST);

  // Current entry under the scan.
  logic          cv;
  logic [OB-1:0] cs, cl;
  logic          fits, take;
  logic [OB:0]   cend, hend;
  assign cv   = fval_r[idx_r];
  assign cs   = fstart_r[idx_r];
  assign cl   = flen_r[idx_r];
  assign fits = cv && (cl >= rsize_r);
  assign cend = {1'b0, cs} + {1'b0, cl};

  always_comb begin
    case (fit_policy)
      POL_BEST:  take = (cl < blen_r) || (cl == blen_r && cs < bstart_r);
      POL_WORST: take = (cl > blen_r) || (cl == blen_r && cs < bstart_r);
      default:   take = cs < bstart_r;
    endcase
  end

  // Neighbour search needs the freed block's bounds first, so the free request
  // reads used_length at the found index; the used lookup is a combinational
  // direct match on the loaded offset, ready ahead of the scan.
  logic          uhit_any;
  logic [IW-1:0] uhit_idx;
  logic [OB-1:0] ulen_sel;
  always_comb begin
    uhit_any = 1'b0;
    uhit_idx = '0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (uval_r[i] && ustart_r[i] == roff_r) begin
        uhit_any = 1'b1;
        uhit_idx = IW'(i);
      end
    end
    ulen_sel = ulen_r[uhit_idx];
  end
  assign hend = {1'b0, roff_r} + {1'b0, ulen_sel};

  logic [OB:0] merged;
  always_comb begin
    merged = {1'b0, hit_len_r};
    if (below_r) merged = merged + {1'b0, flen_r[below_idx_r]};
    if (above_r) merged = merged + {1'b0, flen_r[above_idx_r]};
  end

  logic [1:0]    st_nxt;
  always_comb begin
    if (rtype_r == REQ_ALLOC) begin
      if (rsize_r == '0 || !bfound_r) st_nxt = ST_NOFIT;
      else if (!uemp_found_r)         st_nxt = ST_FULL;
      else                            st_nxt = ST_OK;
    end else begin
      if (!hit_r)                                     st_nxt = ST_UNKNOWN;
      else if (!below_r && !above_r && !femp_found_r) st_nxt = ST_FULL;
      else                                            st_nxt = ST_OK;
    end
  end

  logic [OB:0] sum_after;
  always_comb begin
    sum_after = sum_r;
    if (st_nxt == ST_OK) begin
      if (rtype_r == REQ_ALLOC) sum_after = sum_r - {1'b0, rsize_r};
      else                      sum_after = sum_r + {1'b0, hit_len_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rtype_r <= req_type;
      rsize_r <= OB'(req_size);
      roff_r  <= OB'(block_offset);
    end
    if (cmd.scan_clr) begin
      idx_r <= '0;
      bfound_r <= 1'b0; uemp_found_r <= 1'b0; femp_found_r <= 1'b0;
      above_r <= 1'b0; below_r <= 1'b0; sum_r <= '0;
      bidx_r <= '0; bstart_r <= '0; blen_r <= '0; uemp_r <= '0; femp_r <= '0;
      above_idx_r <= '0; below_idx_r <= '0;
    end
    if (cmd.scan_step) begin
      idx_r <= idx_r + 1'b1;
      if (idx_r == '0) begin
        hit_r     <= uhit_any;
        hit_idx_r <= uhit_idx;
        hit_len_r <= ulen_sel;
      end
      if (cv) sum_r <= sum_r + {1'b0, cl};
      if (fits && (!bfound_r || take)) begin
        bfound_r <= 1'b1; bidx_r <= idx_r; bstart_r <= cs; blen_r <= cl;
      end
      if (!uval_r[idx_r] && !uemp_found_r) begin
        uemp_found_r <= 1'b1; uemp_r <= idx_r;
      end
      if (!cv && !femp_found_r) begin
        femp_found_r <= 1'b1; femp_r <= idx_r;
      end
      if (cv && !above_r && {1'b0, cs} == hend) begin
        above_r <= 1'b1; above_idx_r <= idx_r;
      end
      if (cv && !below_r && cend == {1'b0, roff_r}) begin
        below_r <= 1'b1; below_idx_r <= idx_r;
      end
    end
  end

  // Table updates.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.init) begin
      fval_r <= '0;
      uval_r <= '0;
      if (total_size != 16'd0) fval_r[0] <= 1'b1;
      fstart_r[0] <= '0;
      flen_r[0]   <= OB'(total_size);
    end else if (cmd.commit && st_nxt == ST_OK) begin
      if (rtype_r == REQ_ALLOC) begin
        ustart_r[uemp_r] <= bstart_r;
        ulen_r[uemp_r]   <= rsize_r;
        uval_r[uemp_r]   <= 1'b1;
        if (blen_r == rsize_r) begin
          fval_r[bidx_r] <= 1'b0;
        end else begin
          fstart_r[bidx_r] <= bstart_r + rsize_r;
          flen_r[bidx_r]   <= blen_r - rsize_r;
        end
      end else begin
        uval_r[hit_idx_r] <= 1'b0;
        if (below_r) begin
          flen_r[below_idx_r] <= merged[OB-1:0];
          if (above_r) fval_r[above_idx_r] <= 1'b0;
        end else if (above_r) begin
          fstart_r[above_idx_r] <= roff_r;
          flen_r[above_idx_r]   <= merged[OB-1:0];
        end else begin
          fstart_r[femp_r] <= roff_r;
          flen_r[femp_r]   <= hit_len_r;
          fval_r[femp_r]   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      res_valid_r <= 1'b1;
    end else if (res_take) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      st_r  <= st_nxt;
      ofs_r <= (st_nxt == ST_OK && rtype_r == REQ_ALLOC) ? 16'(bstart_r) : 16'd0;
      fr_r  <= 16'(sum_after);
    end
  end

  assign res_valid  = res_valid_r;
  assign res_status = st_r;
  assign res_offset = ofs_r;
  assign res_free   = fr_r;

endmodule
`default_nettype wire

// ===== hdl/fit_policy_block_allocator_unit.sv =====
// After a request is accepted, the controller scans every table entry in turn,
// then commits; the commit loads the output register that drives out_tvalid.
// A new request is accepted only in the idle state after the previous commit, so
// requests do not overlap; the entry scan sets the time taken per request.
// A result waits in the output register; the next request is taken meanwhile, and
// its commit stalls until the waiting result has been taken.
// Reset (synchronous, rst_n low) and every configuration transaction reload
// the free table with one block of total_size and empty the used table.
`default_nettype none
module fit_policy_block_allocator_unit
  import fpba_pkg::*;
#(
  parameter int MAX_BLOCKS  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // req_type, req_size, block_offset, zero pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // status, alloc_offset, free_bytes, zero pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [15:0] total_size_r;
  logic [1:0]  fit_policy_r;
  fpba_cmd_t   cmd;
  fpba_sts_t   sts;
  logic        in_fire, cfg_fire, res_valid, out_free;
  logic [1:0]  st;
  logic [15:0] ofs, fr;

  assign in_fire  = in_tvalid && in_tready;
  assign cfg_fire = cfg_valid && cfg_ready;
  assign out_free = !res_valid || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_size_r <= 16'hFFFF;
      fit_policy_r <= POL_FIRST;
    end else if (cfg_fire) begin
      case (cfg_index)
        CFG_TOTAL_SIZE: total_size_r <= cfg_data;
        CFG_FIT_POLICY: fit_policy_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  fpba_ctrl u_ctrl (
    .clk, .rst_n, .cfg_write(cfg_valid), .in_fire, .out_free, .sts, .cmd,
    .in_ready(in_tready), .cfg_ready
  );

  fpba_dp #(.MAX_BLOCKS(MAX_BLOCKS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .total_size(total_size_r), .fit_policy(fit_policy_r),
    .req_type(in_tdata[0]), .req_size(in_tdata[16:1]), .block_offset(in_tdata[32:17]),
    .res_valid, .res_take(out_tready), .res_status(st), .res_offset(ofs), .res_free(fr)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = {6'd0, fr, ofs, st};

endmodule
`default_nettype wire

// ===== hdl/fpba_checker.sv =====
// Port-level checker for the fit-policy block allocator, bound to the top level.
// Depends on fpba_pkg.
`default_nettype none
module fpba_checker
  import fpba_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_no_back: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction taken during a request");

  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != ST_OK |-> out_tdata[17:2] == 16'd0)
    else $error("offset not zero on failed request");

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |-> !(in_tvalid && in_tready))
    else $error("configuration and request taken together");

endmodule

bind fit_policy_block_allocator_unit fpba_checker u_fpba_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata,
  .cfg_valid, .cfg_ready
);
`default_nettype wire

// ===== tb/fit_policy_block_allocator_unit_tb.sv =====
// Self-checking testbench for fit_policy_block_allocator_unit: directed and random
// allocate/free requests, scored against an in-bench model of the block tables.
// Depends on fpba_pkg and the allocator RTL only.
`timescale 1ns / 1ps
`default_nettype none
module fit_policy_block_allocator_unit_tb
  import fpba_pkg::*;
();

  localparam int NBLK = 32;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] offset;
    logic [15:0] free_bytes;
  } alloc_result_t;

  typedef struct packed {
    logic          req_type;
    logic [15:0]   size;
    logic [15:0]   offset;
    logic          typed;
    alloc_result_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  always #1 clk = ~clk;

  fit_policy_block_allocator_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the allocator state.
  logic [15:0] region_size;
  logic [1:0]  policy;
  logic [15:0] hole_base [NBLK];
  logic [15:0] hole_len  [NBLK];
  bit          hole_live [NBLK];
  logic [15:0] blk_base  [NBLK];
  logic [15:0] blk_len   [NBLK];
  bit          blk_live  [NBLK];

  alloc_result_t pending_results[$];
  int errors = 0;
  int items_sent = 0;
  int cycles = 0;
  int idle_mode = 0;

  function automatic void clear_tables();
    for (int i = 0; i < NBLK; i++) begin
      hole_live[i] = 0;
      blk_live[i] = 0;
      hole_base[i] = '0;
      hole_len[i] = '0;
      blk_base[i] = '0;
      blk_len[i] = '0;
    end
    if (region_size != 0) begin
      hole_live[0] = 1;
      hole_len[0] = region_size;
    end
  endfunction

  function automatic logic [15:0] free_sum();
    logic [15:0] s;
    s = '0;
    for (int i = 0; i < NBLK; i++)
      if (hole_live[i]) s += hole_len[i];
    return s;
  endfunction

  function automatic int choose_hole(logic [15:0] sz);
    int pick;
    bit take;
    pick = -1;
    for (int i = 0; i < NBLK; i++) begin
      if (!hole_live[i] || hole_len[i] < sz) continue;
      if (pick < 0) begin
        pick = i;
        continue;
      end
      if (policy == POL_BEST)
        take = hole_len[i] < hole_len[pick] ||
               (hole_len[i] == hole_len[pick] && hole_base[i] < hole_base[pick]);
      else if (policy == POL_WORST)
        take = hole_len[i] > hole_len[pick] ||
               (hole_len[i] == hole_len[pick] && hole_base[i] < hole_base[pick]);
      else
        take = hole_base[i] < hole_base[pick];
      if (take) pick = i;
    end
    return pick;
  endfunction

  function automatic alloc_result_t allocate(logic [15:0] sz);
    alloc_result_t r;
    int h, u;
    r = '0;
    u = -1;
    if (sz == 0) r.status = ST_NOFIT;
    else begin
      h = choose_hole(sz);
      if (h < 0) r.status = ST_NOFIT;
      else begin
        for (int i = NBLK - 1; i >= 0; i--)
          if (!blk_live[i]) u = i;
        if (u < 0) r.status = ST_FULL;
        else begin
          r.status = ST_OK;
          r.offset = hole_base[h];
          blk_base[u] = hole_base[h];
          blk_len[u] = sz;
          blk_live[u] = 1;
          if (hole_len[h] == sz) hole_live[h] = 0;
          else begin
            hole_base[h] += sz;
            hole_len[h] -= sz;
          end
        end
      end
    end
    r.free_bytes = free_sum();
    return r;
  endfunction

  function automatic alloc_result_t release_block(logic [15:0] ofs);
    alloc_result_t r;
    int u, lo, hi, f;
    logic [16:0] b_end;
    r = '0;
    u = -1;
    lo = -1;
    hi = -1;
    f = -1;
    for (int i = NBLK - 1; i >= 0; i--)
      if (blk_live[i] && blk_base[i] == ofs) u = i;
    if (u < 0) r.status = ST_UNKNOWN;
    else begin
      b_end = {1'b0, blk_base[u]} + blk_len[u];
      for (int i = 0; i < NBLK; i++) begin
        if (!hole_live[i]) continue;
        if (hi < 0 && {1'b0, hole_base[i]} == b_end) hi = i;
        if (lo < 0 && {1'b0, hole_base[i]} + hole_len[i] == {1'b0, blk_base[u]}) lo = i;
      end
      r.status = ST_OK;
      if (lo >= 0 && hi >= 0) begin
        hole_len[lo] = hole_len[lo] + blk_len[u] + hole_len[hi];
        hole_live[hi] = 0;
      end else if (hi >= 0) begin
        hole_base[hi] = blk_base[u];
        hole_len[hi] += blk_len[u];
      end else if (lo >= 0) begin
        hole_len[lo] += blk_len[u];
      end else begin
        for (int i = NBLK - 1; i >= 0; i--)
          if (!hole_live[i]) f = i;
        if (f < 0) r.status = ST_FULL;
        else begin
          hole_base[f] = blk_base[u];
          hole_len[f] = blk_len[u];
          hole_live[f] = 1;
        end
      end
      if (r.status == ST_OK) blk_live[u] = 0;
    end
    r.free_bytes = free_sum();
    return r;
  endfunction

  task automatic send_request(logic typ, logic [15:0] sz, logic [15:0] ofs,
                              bit typed, alloc_result_t want);
    alloc_result_t r;
    int s_idle;
    in_tvalid <= 1'b1;
    in_tdata <= {7'b0, ofs, sz, typ};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    r = (typ == REQ_ALLOC) ? allocate(sz) : release_block(ofs);
    pending_results.push_back(typed ? want : r);
    items_sent++;
    idle_mode = (items_sent < 633) ? 0 : (items_sent < 1266) ? 1 : 2;
    s_idle = (idle_mode == 0) ? 17 : (idle_mode == 1) ? 46 : 0;
    if ($urandom_range(0, 99) < s_idle) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic write_register(logic idx, logic [15:0] val);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    if (idx == CFG_TOTAL_SIZE) region_size = val;
    else policy = val[1:0];
    clear_tables();
    @(posedge clk);
  endtask

  task automatic random_requests(int count);
    logic [15:0] sz, ofs;
    int live[$];
    for (int n = 0; n < count; n++) begin
      live.delete();
      for (int i = 0; i < NBLK; i++)
        if (blk_live[i]) live.push_back(i);
      sz = 16'($urandom);
      ofs = 16'($urandom);
      case ($urandom_range(0, 19))
        0: sz = '0;
        1, 2: ;
        default: sz = 16'($urandom_range(1, region_size / 6 + 1));
      endcase
      if (live.size() != 0 && $urandom_range(0, 3) != 0)
        ofs = blk_base[live[$urandom_range(0, live.size() - 1)]];
      if ($urandom_range(0, 99) < 55) send_request(REQ_ALLOC, sz, ofs, 0, '0);
      else send_request(REQ_FREE, sz, ofs, 0, '0);
    end
    in_tvalid <= 1'b0;
  endtask

  // Result checker; the receiver stalls according to the current idling mode.
  always @(posedge clk) begin
    alloc_result_t got, want;
    int r_idle;
    r_idle = (idle_mode == 0) ? 46 : (idle_mode == 1) ? 17 : 0;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[1:0], out_tdata[17:2], out_tdata[33:18]};
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction %h", out_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          errors++;
        end
        if (got.offset !== want.offset) begin
          $error("alloc_offset: expected %0d, actual %0d", want.offset, got.offset);
          errors++;
        end
        if (got.free_bytes !== want.free_bytes) begin
          $error("free_bytes: expected %0d, actual %0d", want.free_bytes, got.free_bytes);
          errors++;
        end
      end
    end
    out_tready <= rst_n && ($urandom_range(0, 99) >= r_idle);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  dir_row_t dir_rows[14];
  logic [15:0] phase_size[7] = '{16'd1000, 16'd65535, 16'd40, 16'd1, 16'd0, 16'd5000, 16'd65535};
  logic [1:0]  phase_pol[7] = '{POL_BEST, POL_WORST, POL_SPARE, POL_BEST, POL_WORST, POL_FIRST,
                                POL_BEST};
  int          phase_len[7] = '{250, 250, 250, 20, 20, 250, 250};

  initial begin
    region_size = 16'd65535;
    policy = POL_FIRST;
    clear_tables();
    // Rows with a typed result follow from the reset state and the rows before them.
    dir_rows = '{
      '{REQ_ALLOC, 16'd0,     16'hFFFF, 1, '{ST_NOFIT, 16'd0, 16'd65535}},
      '{REQ_ALLOC, 16'd65535, 16'd0,    1, '{ST_OK, 16'd0, 16'd0}},
      '{REQ_ALLOC, 16'd1,     16'd0,    1, '{ST_NOFIT, 16'd0, 16'd0}},
      '{REQ_FREE,  16'hFFFF,  16'd0,    1, '{ST_OK, 16'd0, 16'd65535}},
      '{REQ_FREE,  16'd0,     16'd0,    1, '{ST_UNKNOWN, 16'd0, 16'd65535}},
      '{REQ_ALLOC, 16'd100,   16'd0,    1, '{ST_OK, 16'd0, 16'd65435}},
      '{REQ_ALLOC, 16'd200,   16'd0,    1, '{ST_OK, 16'd100, 16'd65235}},
      '{REQ_ALLOC, 16'd300,   16'd0,    1, '{ST_OK, 16'd300, 16'd64935}},
      '{REQ_FREE,  16'd0,     16'd100,  0, '0},
      '{REQ_FREE,  16'd0,     16'd0,    0, '0},
      '{REQ_ALLOC, 16'd50,    16'd0,    0, '0},
      '{REQ_FREE,  16'd0,     16'd300,  0, '0},
      '{REQ_FREE,  16'd0,     16'hFFFF, 1, '{ST_UNKNOWN, 16'd0, 16'd65485}},
      '{REQ_FREE,  16'd0,     16'd50,   0, '0}
    };
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i])
      send_request(dir_rows[i].req_type, dir_rows[i].size, dir_rows[i].offset,
                   dir_rows[i].typed, dir_rows[i].res);
    in_tvalid <= 1'b0;
    // Filling the occupied table with unit blocks ends on a table-full status.
    write_register(CFG_TOTAL_SIZE, 16'd64);
    for (int i = 0; i < 33; i++) send_request(REQ_ALLOC, 16'd1, 16'd0, 0, '0);
    in_tvalid <= 1'b0;
    write_register(CFG_TOTAL_SIZE, 16'd65535);
    random_requests(560);
    for (int p = 0; p < 7; p++) begin
      write_register(CFG_TOTAL_SIZE, phase_size[p]);
      write_register(CFG_FIT_POLICY, {14'b0, phase_pol[p]});
      random_requests(phase_len[p]);
    end
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
hdl/fpba_pkg.sv
hdl/fpba_ctrl.sv
hdl/fpba_dp.sv
hdl/fit_policy_block_allocator_unit.sv
hdl/fpba_checker.sv
tb/fit_policy_block_allocator_unit_tb.sv
